### src/bounded_unsorted_list_engine_defines.svh
// Assertion macros for the bounded unsorted list engine.
// Depends on a clock named clock and an active high reset named reset in the using module.
`ifndef BOUNDED_UNSORTED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_UNSORTED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define BULE_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define BULE_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

### src/bule_pkg.sv
// Shared types and codes for the bounded unsorted list engine.
// No dependencies.
package bule_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 16;

   // command codes
   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_END   = 3'd1;
   localparam logic [2:0] CMD_FIND      = 3'd2;
   localparam logic [2:0] CMD_DEL_VALUE = 3'd3;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd4;
   localparam logic [2:0] CMD_DEL_END   = 3'd5;
   localparam logic [2:0] CMD_NEXT      = 3'd6;

   // status codes
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_FULL      = 3'd1;
   localparam logic [2:0] STS_EMPTY     = 3'd2;
   localparam logic [2:0] STS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STS_END       = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_SHIFT_DN,
      ST_SHIFT_UP,
      ST_WR_HEAD,
      ST_ITER_RD,
      ST_DONE
   } state_type;

endpackage

### src/bounded_unsorted_list_engine.sv
// Bounded unsorted list engine: sequencer around a single entry memory.
// Depends on bule_pkg and bounded_unsorted_list_engine_defines.svh.

// The list lives in one DEPTH-entry memory with a registered read port, and a
// sequencer walks it one entry per cycle. One command is in flight at a time
// and each gives one response word. Find and delete value walk the entries
// from the head until a hit or the list end, delete value and delete front
// then move the entries behind it down one place, and insert front moves
// every entry up one place before it writes the new head; the memory takes
// one read and one write per cycle. A new command is accepted while the
// previous response still waits on the output; it only holds at completion
// until that response is taken. Store contents need no clearing after reset.
`include "bounded_unsorted_list_engine_defines.svh"

module bounded_unsorted_list_engine #(
   parameter int DEPTH       = bule_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = bule_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // item_value[15:0]
   input  logic [2:0]  req_tuser,   // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // value_out[15:0], list_length[20:16], zero[23:21]
   output logic [3:0]  rsp_tuser    // status[2:0], found[3]
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int CW1 = CW + 1;

   bule_pkg::state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] entry_store_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] rdata_ff;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [AW-1:0]          mem_raddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;

   logic [2:0]             cmd_ff, cmd_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic                   act_ff, act_in;

   logic [2:0]  res_status_ff, res_status_in;
   logic        res_found_ff, res_found_in;
   logic [15:0] res_vout_ff, res_vout_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [15:0] rsp_vout_ff, rsp_vout_in;
   logic [4:0]  rsp_len_ff, rsp_len_in;

   logic [63:0] req_wide, rd_wide;
   logic [31:0] count_wide;
   logic [CW1-1:0] ptr_p1, ptr_p2, pos_p1, count_x;
   logic is_full, is_empty, is_one, hit, ptr_last, ptr2_last, pos_last, slot_free;

   assign req_wide   = 64'(req_tdata);
   assign rd_wide    = 64'(rdata_ff);
   assign count_wide = 32'(count_ff);

   assign count_x   = CW1'(count_ff);
   assign ptr_p1    = CW1'(ptr_ff) + CW1'(1);
   assign ptr_p2    = CW1'(ptr_ff) + CW1'(2);
   assign pos_p1    = CW1'(pos_ff) + CW1'(1);
   assign is_full   = count_ff == CW'(DEPTH);
   assign is_empty  = count_ff == '0;
   assign is_one    = count_ff == CW'(1);
   assign hit       = rdata_ff == val_ff;
   assign ptr_last  = ptr_p1 >= count_x;
   assign ptr2_last = ptr_p2 >= count_x;
   assign pos_last  = pos_p1 >= count_x;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = state_ff == bule_pkg::ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_len_ff, rsp_vout_ff};
   assign rsp_tuser  = {rsp_found_ff, rsp_status_ff};

   // entry store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_store_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= entry_store_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bule_pkg::ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_vout_ff   <= res_vout_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_vout_ff   <= rsp_vout_in;
      rsp_len_ff    <= rsp_len_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bule_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = bule_pkg::ST_DECODE;
         end
         bule_pkg::ST_DECODE: begin
            unique case (cmd_ff) inside
               bule_pkg::CMD_INS_FRONT: begin
                  if (is_full) state_in = bule_pkg::ST_DONE;
                  else if (is_empty) state_in = bule_pkg::ST_WR_HEAD;
                  else state_in = bule_pkg::ST_SHIFT_UP;
               end
               bule_pkg::CMD_FIND, bule_pkg::CMD_DEL_VALUE: begin
                  state_in = is_empty ? bule_pkg::ST_DONE : bule_pkg::ST_SEARCH;
               end
               bule_pkg::CMD_DEL_FRONT: begin
                  state_in = (is_empty || is_one) ? bule_pkg::ST_DONE : bule_pkg::ST_SHIFT_DN;
               end
               bule_pkg::CMD_NEXT: begin
                  if (is_empty || (act_ff && pos_last)) state_in = bule_pkg::ST_DONE;
                  else state_in = bule_pkg::ST_ITER_RD;
               end
               default: state_in = bule_pkg::ST_DONE;
            endcase
         end
         bule_pkg::ST_SEARCH: begin
            if (hit) begin
               if (cmd_ff == bule_pkg::CMD_DEL_VALUE && !ptr_last) begin
                  state_in = bule_pkg::ST_SHIFT_DN;
               end else begin
                  state_in = bule_pkg::ST_DONE;
               end
            end else if (ptr_last) begin
               state_in = bule_pkg::ST_DONE;
            end
         end
         bule_pkg::ST_SHIFT_DN: begin
            if (ptr2_last) state_in = bule_pkg::ST_DONE;
         end
         bule_pkg::ST_SHIFT_UP: begin
            if (ptr_ff == '0) state_in = bule_pkg::ST_WR_HEAD;
         end
         bule_pkg::ST_WR_HEAD: state_in = bule_pkg::ST_DONE;
         bule_pkg::ST_ITER_RD: state_in = bule_pkg::ST_DONE;
         bule_pkg::ST_DONE: begin
            if (slot_free) state_in = bule_pkg::ST_IDLE;
         end
         default: state_in = bule_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      act_in        = act_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_vout_in   = res_vout_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_vout_in   = rsp_vout_ff;
      rsp_len_in    = rsp_len_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = val_ff;
      mem_raddr     = '0;

      unique case (state_ff)
         bule_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser;
               val_in = req_wide[VALUE_WIDTH-1:0];
            end
         end
         bule_pkg::ST_DECODE: begin
            res_status_in = bule_pkg::STS_OK;
            res_found_in  = 1'b0;
            res_vout_in   = '0;
            unique case (cmd_ff) inside
               bule_pkg::CMD_INS_FRONT: begin
                  if (is_full) begin
                     res_status_in = bule_pkg::STS_FULL;
                  end else if (!is_empty) begin
                     // start the move-up walk at the tail
                     mem_raddr = AW'(count_ff - CW'(1));
                     ptr_in    = AW'(count_ff - CW'(1));
                  end
               end
               bule_pkg::CMD_INS_END: begin
                  if (is_full) begin
                     res_status_in = bule_pkg::STS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(count_ff);
                     count_in  = count_ff + CW'(1);
                     pos_in    = '0;
                     act_in    = 1'b0;
                  end
               end
               bule_pkg::CMD_FIND, bule_pkg::CMD_DEL_VALUE: begin
                  if (is_empty) begin
                     res_status_in = bule_pkg::STS_EMPTY;
                  end else begin
                     ptr_in = '0;
                  end
               end
               bule_pkg::CMD_DEL_FRONT: begin
                  if (is_empty) begin
                     res_status_in = bule_pkg::STS_EMPTY;
                  end else if (is_one) begin
                     count_in = '0;
                     pos_in   = '0;
                     act_in   = 1'b0;
                  end else begin
                     mem_raddr = AW'(1);
                     ptr_in    = '0;
                  end
               end
               bule_pkg::CMD_DEL_END: begin
                  if (is_empty) begin
                     res_status_in = bule_pkg::STS_EMPTY;
                  end else begin
                     count_in = count_ff - CW'(1);
                     pos_in   = '0;
                     act_in   = 1'b0;
                  end
               end
               bule_pkg::CMD_NEXT: begin
                  if (is_empty) begin
                     res_status_in = bule_pkg::STS_EMPTY;
                  end else if (!act_ff) begin
                     act_in = 1'b1;
                     pos_in = '0;
                  end else if (pos_last) begin
                     res_status_in = bule_pkg::STS_END;
                     pos_in        = AW'(count_ff - CW'(1));
                  end else begin
                     mem_raddr = AW'(pos_p1);
                     pos_in    = AW'(pos_p1);
                  end
               end
               default: ;
            endcase
         end
         bule_pkg::ST_SEARCH: begin
            // read of the following entry is issued whatever the compare gives
            mem_raddr = AW'(ptr_p1);
            if (hit) begin
               res_status_in = bule_pkg::STS_OK;
               res_found_in  = 1'b1;
               if (cmd_ff == bule_pkg::CMD_DEL_VALUE && ptr_last) begin
                  count_in = count_ff - CW'(1);
                  pos_in   = '0;
                  act_in   = 1'b0;
               end
            end else if (ptr_last) begin
               res_status_in = bule_pkg::STS_NOT_FOUND;
            end else begin
               ptr_in = AW'(ptr_p1);
            end
         end
         bule_pkg::ST_SHIFT_DN: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rdata_ff;
            if (ptr2_last) begin
               count_in = count_ff - CW'(1);
               pos_in   = '0;
               act_in   = 1'b0;
            end else begin
               mem_raddr = AW'(ptr_p2);
               ptr_in    = AW'(ptr_p1);
            end
         end
         bule_pkg::ST_SHIFT_UP: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(ptr_p1);
            mem_wdata = rdata_ff;
            if (ptr_ff != '0) begin
               mem_raddr = ptr_ff - AW'(1);
               ptr_in    = ptr_ff - AW'(1);
            end
         end
         bule_pkg::ST_WR_HEAD: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            count_in  = count_ff + CW'(1);
            pos_in    = '0;
            act_in    = 1'b0;
         end
         bule_pkg::ST_ITER_RD: begin
            res_vout_in = rd_wide[15:0];
         end
         bule_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_vout_in   = res_vout_ff;
               rsp_len_in    = count_wide[4:0];
            end
         end
         default: ;
      endcase
   end

   `BULE_ASSERT_IMP(a_iter_in_list, act_ff, CW'(pos_ff) < count_ff, "iterator beyond list end")
   `BULE_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == bule_pkg::ST_DONE, "response raised outside completion")
   `BULE_ASSERT_NXT(a_idle_keeps_list, state_ff == bule_pkg::ST_IDLE, $stable(count_ff) && $stable(act_ff), "list state moved while idle")

endmodule
